// ----- rtl/core/erle_pkg.sv -----
// ---------------------------------------------------------------------------
// erle_pkg
// Shared constants and types for the escaped run-length encoder.
// ---------------------------------------------------------------------------
package erle_pkg;

  localparam int WORD_BITS_DEF = 16;
  // Most words one source beat can produce: old-run triple plus new-run triple
  localparam int MAX_OUT       = 6;
  localparam int CNT_BITS      = $clog2(MAX_OUT + 1);

  typedef struct packed {
    logic [CNT_BITS-1:0] count;
    logic [MAX_OUT-1:0]  last;
  } erle_emit_t;

endpackage

// ----- rtl/core/erle_pack.sv -----
// ---------------------------------------------------------------------------
// erle_pack
// Builds the encoded word list for one source beat and the next run state.
// ---------------------------------------------------------------------------
module erle_pack import erle_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic [WORD_BITS-1:0] run_value,
  input  logic [WORD_BITS-1:0] run_length,
  input  logic [WORD_BITS-1:0] word,
  input  logic                 last,
  output logic [WORD_BITS-1:0] emit_word [MAX_OUT],
  output erle_emit_t           emit,
  output logic [WORD_BITS-1:0] value_next,
  output logic [WORD_BITS-1:0] length_next
);

  localparam logic [WORD_BITS-1:0] LEN_MAX = '1;
  localparam logic [WORD_BITS-1:0] LEN_ONE = WORD_BITS'(1);
  localparam logic [WORD_BITS-1:0] LEN_TWO = WORD_BITS'(2);

  logic                 close_old;
  logic                 fresh;
  logic [WORD_BITS-1:0] val_b;
  logic [WORD_BITS-1:0] len_b;
  logic [WORD_BITS-1:0] a_w [3];
  logic [WORD_BITS-1:0] b_w [3];
  logic [1:0]           a_n;
  logic [1:0]           b_n;

  assign close_old = (run_length != '0) &&
                     ((word != run_value) || (run_length == LEN_MAX));
  assign fresh     = close_old || (run_length == '0);
  assign val_b     = fresh ? word : run_value;
  assign len_b     = fresh ? LEN_ONE : run_length + LEN_ONE;

  assign value_next  = val_b;
  assign length_next = last ? '0 : len_b;

  // Flush of the run being closed by a different or overflowing word
  always_comb begin
    a_w[0] = run_value;
    a_w[1] = run_value;
    a_w[2] = run_value;
    a_n    = 2'd0;
    if (close_old) begin
      if ((run_length > LEN_TWO) || (run_value == '0)) begin
        a_w[0] = '0;
        a_w[1] = run_length;
        a_n    = 2'd3;
      end else begin
        a_n    = run_length[1:0];
      end
    end
  end

  // Flush of the run that holds the last-marked word
  always_comb begin
    b_w[0] = val_b;
    b_w[1] = val_b;
    b_w[2] = val_b;
    b_n    = 2'd0;
    if (last) begin
      if ((len_b > LEN_TWO) || (val_b == '0)) begin
        b_w[0] = '0;
        b_w[1] = len_b;
        b_n    = 2'd3;
      end else begin
        b_n    = len_b[1:0];
      end
    end
  end

  // Concatenate both flushes into one word list
  always_comb begin
    logic [CNT_BITS-1:0] j;
    j          = '0;
    emit.count = CNT_BITS'(a_n) + CNT_BITS'(b_n);
    emit.last  = '0;
    for (int i = 0; i < MAX_OUT; i++) begin
      emit_word[i] = '0;
      j            = CNT_BITS'(i) - CNT_BITS'(a_n);
      if (CNT_BITS'(i) < CNT_BITS'(a_n)) begin
        emit_word[i] = a_w[2'(i)];
      end else if (j < CNT_BITS'(b_n)) begin
        emit_word[i] = b_w[j[1:0]];
        emit.last[i] = last && (j == CNT_BITS'(b_n) - CNT_BITS'(1));
      end
    end
  end

endmodule

// ----- rtl/core/escaped_run_length_encoder.sv -----
// ---------------------------------------------------------------------------
// escaped_run_length_encoder
// Run-length encoder with a zero escape: long runs and zero runs become (0, count, value).
// ---------------------------------------------------------------------------
// Source words enter on the s_ side and encoded words leave on the m_ side,
// one word per beat. A beat that extends an open run produces nothing and a
// beat that closes a run of one nonzero word produces one word, so such
// streams pass at one beat per cycle while m_tready is high. A beat that
// produces n words (up to six: the flush of the previous run plus the flush
// of a last-marked run) loads a six-entry output buffer that drains one word
// per cycle while m_tready is high, and s_tready stays low while it drains;
// the next beat is taken in the cycle the final buffered word leaves. Runs
// longer than two, and every run of zero, go out as 0, count, value; shorter
// runs go out as literal words. Runs split at the largest count a word
// holds, and the final word of a block has tlast.
// ---------------------------------------------------------------------------
module escaped_run_length_encoder import erle_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((WORD_BITS + 7) / 8) * 8-1:0] s_tdata,  // word_in
  input  logic                                 s_tlast,  // last_in
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((WORD_BITS + 7) / 8) * 8-1:0] m_tdata,  // word_out
  output logic                                 m_tlast   // last_out
);

  localparam int DATA_BITS = ((WORD_BITS + 7) / 8) * 8;

  logic [WORD_BITS-1:0] run_value;
  logic [WORD_BITS-1:0] run_length;
  logic [WORD_BITS-1:0] value_next;
  logic [WORD_BITS-1:0] length_next;
  logic [WORD_BITS-1:0] emit_word [MAX_OUT];
  erle_emit_t           emit;

  logic [WORD_BITS-1:0] pend_word [MAX_OUT];
  logic [MAX_OUT-1:0]   pend_last;
  logic [CNT_BITS-1:0]  pend_cnt;

  logic accept;
  logic pop;

  erle_pack #(
    .WORD_BITS (WORD_BITS)
  ) u_pack (
    .run_value   (run_value),
    .run_length  (run_length),
    .word        (s_tdata[WORD_BITS-1:0]),
    .last        (s_tlast),
    .emit_word   (emit_word),
    .emit        (emit),
    .value_next  (value_next),
    .length_next (length_next)
  );

  assign m_tvalid = (pend_cnt != '0);
  assign m_tdata  = DATA_BITS'(pend_word[0]);
  assign m_tlast  = pend_last[0];
  assign pop      = m_tvalid && m_tready;
  // Take a beat once the buffer is empty or its final word leaves now
  assign s_tready = (pend_cnt == '0) || ((pend_cnt == CNT_BITS'(1)) && m_tready);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt   <= '0;
      run_value  <= '0;
      run_length <= '0;
    end else if (accept) begin
      pend_cnt   <= emit.count;
      run_value  <= value_next;
      run_length <= length_next;
    end else if (pop) begin
      pend_cnt   <= pend_cnt - CNT_BITS'(1);
    end
  end

  // Load the word list, or advance it by one word per beat out
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_word <= emit_word;
      pend_last <= emit.last;
    end else if (pop) begin
      for (int i = 0; i < MAX_OUT - 1; i++) begin
        pend_word[i] <= pend_word[i + 1];
      end
      pend_last <= pend_last >> 1;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    pend_cnt <= CNT_BITS'(MAX_OUT))
    else $error("output buffer count out of range");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> (run_length == '0) && m_tvalid)
    else $error("last beat did not close and flush the run");

  a_open_run: assert property (@(posedge clk) disable iff (rst)
    accept && !s_tlast |=> run_length != '0)
    else $error("no run open after a non-last beat");

  a_break_emits: assert property (@(posedge clk) disable iff (rst)
    accept && (run_length != '0) && (s_tdata[WORD_BITS-1:0] != run_value) |=> m_tvalid)
    else $error("changed word did not flush the previous run");

endmodule
